### rtl/core/s384_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s384_pkg
// shared types, constants and round tables of the sha-384 stream hasher
// ----------------------------------------------------------------------------
package s384_pkg;

   localparam logic [6:0] InputWordBits = 7'd64;

   typedef struct packed {
      logic [63:0] msg_word;
      logic [6:0]  valid_bits;
      logic        last_word;
   } item_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_PAD,
      ST_FILL,
      ST_ROUND,
      ST_FEED,
      ST_OUT
   } engine_state_type;

   function automatic logic [63:0] init_hash(input logic [2:0] idx);
      logic [63:0] r;
      case (idx)
         3'd0:    r = 64'hcbbb9d5dc1059ed8;
         3'd1:    r = 64'h629a292a367cd507;
         3'd2:    r = 64'h9159015a3070dd17;
         3'd3:    r = 64'h152fecd8f70e5939;
         3'd4:    r = 64'h67332667ffc00b31;
         3'd5:    r = 64'h8eb44a8768581511;
         3'd6:    r = 64'hdb0c2e0d64f98fa7;
         default: r = 64'h47b5481dbefa4fa4;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] round_k(input logic [6:0] t);
      logic [63:0] r;
      case (t)
         7'd0:  r = 64'h428a2f98d728ae22; 7'd1:  r = 64'h7137449123ef65cd;
         7'd2:  r = 64'hb5c0fbcfec4d3b2f; 7'd3:  r = 64'he9b5dba58189dbbc;
         7'd4:  r = 64'h3956c25bf348b538; 7'd5:  r = 64'h59f111f1b605d019;
         7'd6:  r = 64'h923f82a4af194f9b; 7'd7:  r = 64'hab1c5ed5da6d8118;
         7'd8:  r = 64'hd807aa98a3030242; 7'd9:  r = 64'h12835b0145706fbe;
         7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
         7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
         7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
         7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
         7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
         7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
         7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
         7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
         7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
         7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
         7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
         7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
         7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
         7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
         7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
         7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
         7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
         7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
         7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
         7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
         7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
         7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
         7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
         7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
         7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
         7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
         7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
         7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
         7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
         7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
         7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
         7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
         7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
         7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
         7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
         default: r = 64'd0;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

endpackage

### rtl/core/s384_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s384_front
// accepts words, clamps the bit count and clears the unused low bits
// ----------------------------------------------------------------------------
module s384_front
   import s384_pkg::*;
(
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [63:0]      req_msg_word,
   input  logic [6:0]       req_valid_bits,
   input  logic             req_last_word,
   input  queue_status_type q_status,
   output logic             push,
   output item_type         push_item
);

   logic [6:0] count_sat;

   always_comb begin
      count_sat = (req_valid_bits > InputWordBits) ? InputWordBits : req_valid_bits;
      push_item.msg_word   = req_msg_word & ~(64'hffff_ffff_ffff_ffff >> count_sat);
      push_item.valid_bits = count_sat;
      push_item.last_word  = req_last_word;
   end

   assign req_stall = q_status.full;
   assign push      = req_valid & ~q_status.full;

endmodule

### rtl/core/s384_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s384_queue
// two-entry word queue between front and compression engine
// ----------------------------------------------------------------------------
module s384_queue
   import s384_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head_item,
   output queue_status_type q_status
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      q_status.not_empty = (count_ff != 2'd0);
      q_status.full      = (count_ff == 2'd2);
      head_item = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0) else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != 2'd2) else $error("push into full queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");

endmodule

### rtl/core/s384_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s384_engine
// bit packing, padding, sha-512 rounds and digest output
// ----------------------------------------------------------------------------
module s384_engine
   import s384_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  item_type         head_item,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [63:0]      rsp_digest_word,
   output logic             rsp_digest_last
);

   engine_state_type state_ff, state_in;

   logic [127:0] acc_ff;
   logic [6:0]   acc_cnt_ff;
   logic [3:0]   widx_ff;
   logic [127:0] len_ff;
   logic         last_ff, pad_ff, len_done_ff;
   logic [6:0]   rnd_ff;
   logic [2:0]   oidx_ff;
   logic [63:0]  w_ff    [16];
   logic [63:0]  v_ff    [8];
   logic [63:0]  hash_ff [8];
   logic         rsp_valid_ff;
   logic [63:0]  rsp_word_ff;
   logic         rsp_last_ff;

   logic         out_load;
   logic [63:0]  w_new, t1, t2;

   always_comb begin
      w_new = w_ff[0] + (rotr(w_ff[1], 1) ^ rotr(w_ff[1], 8) ^ (w_ff[1] >> 7))
            + w_ff[9] + (rotr(w_ff[14], 19) ^ rotr(w_ff[14], 61) ^ (w_ff[14] >> 6));
      t1 = v_ff[7] + (rotr(v_ff[4], 14) ^ rotr(v_ff[4], 18) ^ rotr(v_ff[4], 41))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(rnd_ff) + w_ff[0];
      t2 = (rotr(v_ff[0], 28) ^ rotr(v_ff[0], 34) ^ rotr(v_ff[0], 39))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign pop      = (state_ff == ST_IDLE) && q_status.not_empty;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (acc_cnt_ff >= 7'd64 && widx_ff == 4'd15) state_in = ST_ROUND;
            else if (last_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_PAD: state_in = ST_FILL;
         ST_FILL: begin
            if ((widx_ff == 4'd14 && acc_cnt_ff == 7'd0) || widx_ff == 4'd15) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (rnd_ff == 7'd79) state_in = ST_FEED;
         end
         ST_FEED: begin
            if (len_done_ff) state_in = ST_OUT;
            else if (pad_ff) state_in = ST_FILL;
            else if (last_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (out_load && oidx_ff == 3'd5) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= 128'd0;
         acc_cnt_ff  <= 7'd0;
         widx_ff     <= 4'd0;
         len_ff      <= 128'd0;
         last_ff     <= 1'b0;
         pad_ff      <= 1'b0;
         len_done_ff <= 1'b0;
         rnd_ff      <= 7'd0;
         oidx_ff     <= 3'd0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= init_hash(3'(i));
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (q_status.not_empty) begin
                  acc_ff     <= acc_ff | ({head_item.msg_word, 64'd0} >> acc_cnt_ff);
                  acc_cnt_ff <= acc_cnt_ff + head_item.valid_bits;
                  len_ff     <= len_ff + {121'd0, head_item.valid_bits};
                  last_ff    <= head_item.last_word;
               end
            end
            ST_FLUSH: begin
               if (acc_cnt_ff >= 7'd64) begin
                  w_ff[widx_ff] <= acc_ff[127:64];
                  acc_ff        <= {acc_ff[63:0], 64'd0};
                  acc_cnt_ff    <= acc_cnt_ff - 7'd64;
                  widx_ff       <= widx_ff + 4'd1;
                  if (widx_ff == 4'd15) begin
                     rnd_ff <= 7'd0;
                     for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[i];
                  end
               end
            end
            ST_PAD: begin
               acc_ff     <= acc_ff | (128'd1 << (7'd127 - acc_cnt_ff));
               acc_cnt_ff <= acc_cnt_ff + 7'd1;
               pad_ff     <= 1'b1;
            end
            ST_FILL: begin
               if (widx_ff == 4'd14 && acc_cnt_ff == 7'd0) begin
                  w_ff[14]    <= len_ff[127:64];
                  w_ff[15]    <= len_ff[63:0];
                  widx_ff     <= 4'd0;
                  len_done_ff <= 1'b1;
               end else begin
                  w_ff[widx_ff] <= acc_ff[127:64];
                  acc_ff        <= {acc_ff[63:0], 64'd0};
                  acc_cnt_ff    <= (acc_cnt_ff >= 7'd64) ? acc_cnt_ff - 7'd64 : 7'd0;
                  widx_ff       <= widx_ff + 4'd1;
               end
               rnd_ff <= 7'd0;
               for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[i];
            end
            ST_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
               w_ff[15] <= w_new;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff  <= rnd_ff + 7'd1;
            end
            ST_FEED: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + v_ff[i];
               oidx_ff <= 3'd0;
            end
            ST_OUT: begin
               if (out_load) begin
                  oidx_ff <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd5) begin
                     acc_ff      <= 128'd0;
                     acc_cnt_ff  <= 7'd0;
                     widx_ff     <= 4'd0;
                     len_ff      <= 128'd0;
                     last_ff     <= 1'b0;
                     pad_ff      <= 1'b0;
                     len_done_ff <= 1'b0;
                     for (int i = 0; i < 8; i++) hash_ff[i] <= init_hash(3'(i));
                  end
               end
            end
            default: begin
               rnd_ff <= 7'd0;
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_word_ff <= hash_ff[oidx_ff];
         rsp_last_ff <= (oidx_ff == 3'd5);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_digest_last = rsp_last_ff;

   a_idle_acc: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> acc_cnt_ff < 7'd64) else $error("bit accumulator overrun");
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> rnd_ff <= 7'd79) else $error("round counter overrun");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT) else $error("stray digest word");

endmodule

### rtl/core/sha384_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha384_stream_hasher
// streaming sha-384: bit-granular message words in, six digest words out
// ----------------------------------------------------------------------------
// Each word carries up to 64 message bits, msb first, with a bit count and a
// last flag. A two-entry queue decouples input from the engine. Each word
// is packed in the idle and flush states, the second of which also loads
// the round registers when it completes a block; each full 1024-bit block
// then runs 80 rounds of the shared round unit and a feed-forward, during
// which the engine takes no new word from the queue, and narrower words
// cost less per word. After the last word, padding runs the pad and fill
// states and adds one or two blocks, then the six digest words leave
// through a registered output, one per cycle when not stalled.
module sha384_stream_hasher
   import s384_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_msg_word,
   input  logic [6:0]  req_valid_bits,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic        rsp_digest_last
);

   queue_status_type q_status;
   item_type         push_item;
   item_type         head_item;
   logic             push;
   logic             pop;

   s384_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_msg_word   (req_msg_word),
      .req_valid_bits (req_valid_bits),
      .req_last_word  (req_last_word),
      .q_status       (q_status),
      .push           (push),
      .push_item      (push_item)
   );

   s384_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   s384_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .head_item       (head_item),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_digest_last (rsp_digest_last)
   );

endmodule
